// File: design/rmrlp_pkg.sv
`timescale 1ns / 1ps

package rmrlp_pkg;

  // panel and store geometry
  localparam int PANEL_SHORT = 480;
  localparam int PANEL_LONG  = 800;
  localparam int ROW_BYTES   = 100;
  localparam int STORE_BYTES = 48000;

  // field widths
  localparam int XY_W     = 12;
  localparam int SIZE_W   = 10;
  localparam int BADDR_W  = 16;
  localparam int REQ_W    = 3;
  localparam int MARGIN_W = 8;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;

  // internal widths
  localparam int COORD_W = 14;  // holds any offset coordinate incl. margin
  localparam int CNT_W   = 12;  // run length minus one
  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int PX_W    = $clog2(PANEL_SHORT);
  localparam int PY_W    = $clog2(PANEL_LONG);
  localparam int IDX_MAX = (PANEL_SHORT - 1) * ROW_BYTES + (PANEL_LONG - 1) / 8;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam int WIDE_W  = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LEFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_TOP  = 2'd1;

  localparam logic [MARGIN_W-1:0] MARGIN_LEFT_RST = 8'd10;
  localparam logic [MARGIN_W-1:0] MARGIN_TOP_RST  = 8'd11;

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL   = 3'd0,
    REQ_LINE    = 3'd1,
    REQ_OUTLINE = 3'd2,
    REQ_FILL    = 3'd3,
    REQ_INVERT  = 3'd4,
    REQ_READ    = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    SEG_PIXEL  = 3'd0,
    SEG_LINE   = 3'd1,
    SEG_TOP    = 3'd2,
    SEG_BOTTOM = 3'd3,
    SEG_LEFT   = 3'd4,
    SEG_RIGHT  = 3'd5,
    SEG_FILL   = 3'd6
  } seg_t;

  typedef struct packed {
    logic load;
    logic invert;
    logic seg_load;
    seg_t seg;
    logic addr_stage;
    logic pix_read;
    logic pix_write;
    logic advance;
    logic byte_read;
    logic byte_capture;
    logic res_load;
    logic res_status;
    logic res_read;
    logic clear_write;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_diag;
    logic rect_empty;
    logic pix_ok;
    logic pix_last;
  } dp_stat_t;

endpackage

// File: design/rmrlp_ram.sv
`timescale 1ns / 1ps

module rmrlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rmrlp_ctrl.sv
`timescale 1ns / 1ps

module rmrlp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rmrlp_pkg::REQ_W-1:0]   req_type,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  rmrlp_pkg::dp_stat_t           stat,
  output rmrlp_pkg::dp_cmd_t            cmd
);

  import rmrlp_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SEG    = 8'b0000_0100,
    S_ADDR   = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_WRITE  = 8'b0010_0000,
    S_RDREQ  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  req_t       op, op_next;
  logic [1:0] seg_idx, seg_idx_next;
  logic       diag, diag_next;
  logic       rd_wait, rd_wait_next;
  logic       out_valid_next;

  // state after the last pixel of a run
  state_t     seg_end_state;
  logic [1:0] seg_end_idx;

  always_comb begin
    if (op == REQ_OUTLINE && seg_idx != 2'd3) begin
      seg_end_state = S_SEG;
      seg_end_idx   = seg_idx + 2'd1;
    end else begin
      seg_end_state = S_DONE;
      seg_end_idx   = seg_idx;
    end
  end

  always_comb begin
    state_next   = state;
    op_next      = op;
    seg_idx_next = seg_idx;
    diag_next    = diag;
    rd_wait_next = 1'b0;
    cmd          = '0;
    cmd.seg      = SEG_PIXEL;
    case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          op_next      = req_t'(req_type);
          seg_idx_next = 2'd0;
          diag_next    = 1'b0;
          case (req_t'(req_type))
            REQ_PIXEL, REQ_LINE, REQ_OUTLINE, REQ_FILL: state_next = S_SEG;
            REQ_INVERT: begin
              cmd.invert = 1'b1;
              state_next = S_DONE;
            end
            REQ_READ: state_next = S_RDREQ;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_SEG: begin
        case (op)
          REQ_LINE: cmd.seg = SEG_LINE;
          REQ_FILL: cmd.seg = SEG_FILL;
          REQ_OUTLINE: begin
            case (seg_idx)
              2'd0:    cmd.seg = SEG_TOP;
              2'd1:    cmd.seg = SEG_BOTTOM;
              2'd2:    cmd.seg = SEG_LEFT;
              default: cmd.seg = SEG_RIGHT;
            endcase
          end
          default: cmd.seg = SEG_PIXEL;
        endcase
        if (op == REQ_LINE && stat.is_diag) begin
          diag_next  = 1'b1;
          state_next = S_DONE;
        end else if ((op inside {REQ_OUTLINE, REQ_FILL}) && stat.rect_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.seg_load = 1'b1;
          state_next   = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr_stage = 1'b1;
        if (stat.pix_ok) begin
          state_next = S_READ;
        end else begin
          cmd.advance = 1'b1;
          if (stat.pix_last) begin
            state_next   = seg_end_state;
            seg_idx_next = seg_end_idx;
          end
        end
      end
      S_READ: begin
        cmd.pix_read = 1'b1;
        state_next   = S_WRITE;
      end
      S_WRITE: begin
        cmd.pix_write = 1'b1;
        cmd.advance   = 1'b1;
        if (stat.pix_last) begin
          state_next   = seg_end_state;
          seg_idx_next = seg_end_idx;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_RDREQ: begin
        if (rd_wait) begin
          cmd.byte_capture = 1'b1;
          state_next       = S_DONE;
        end else begin
          cmd.byte_read = 1'b1;
          rd_wait_next  = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = diag;
          cmd.res_read   = (op == REQ_READ);
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      op        <= REQ_PIXEL;
      seg_idx   <= 2'd0;
      diag      <= 1'b0;
      rd_wait   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      seg_idx   <= seg_idx_next;
      diag      <= diag_next;
      rd_wait   <= rd_wait_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

// File: design/rmrlp_datapath.sv
`timescale 1ns / 1ps

module rmrlp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rmrlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmrlp_pkg::MARGIN_W-1:0]       cfg_data,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    x_a,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    y_a,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    x_b,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    y_b,
  input  logic [rmrlp_pkg::SIZE_W-1:0]         rect_width,
  input  logic [rmrlp_pkg::SIZE_W-1:0]         rect_height,
  input  logic                                 ink,
  input  logic [rmrlp_pkg::BADDR_W-1:0]        byte_addr,
  input  rmrlp_pkg::dp_cmd_t                   cmd,
  output rmrlp_pkg::dp_stat_t                  stat,
  output logic                                 status,
  output logic [rmrlp_pkg::BYTE_W-1:0]         read_data
);

  import rmrlp_pkg::*;

  // configuration
  logic [MARGIN_W-1:0] margin_left, margin_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin_left <= MARGIN_LEFT_RST;
      margin_top  <= MARGIN_TOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MARGIN_LEFT: margin_left <= cfg_data;
        CFG_MARGIN_TOP:  margin_top  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic signed [XY_W-1:0] xa_r, ya_r, xb_r, yb_r;
  logic [SIZE_W-1:0]      w_r, h_r;
  logic                   ink_r;
  logic [BADDR_W-1:0]     baddr_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xa_r    <= x_a;
      ya_r    <= y_a;
      xb_r    <= x_b;
      yb_r    <= y_b;
      w_r     <= rect_width;
      h_r     <= rect_height;
      ink_r   <= ink;
      baddr_r <= byte_addr;
    end
  end

  // polarity of the store: stored byte = visible byte xor inv
  logic inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv <= 1'b0;
    end else if (cmd.invert) begin
      inv <= ~inv;
    end
  end

  // clearing pass counter
  logic [ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_write) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // run setup
  logic signed [COORD_W-1:0] xs, ys, xbs, ybs, wc, hc, x_end, y_end;
  logic signed [COORD_W-1:0] dx, dy, adx, ady, x_min, y_min;
  logic [CNT_W-1:0]          w_last, h_last;
  logic                      is_vert, is_horz;

  always_comb begin
    xs     = COORD_W'(xa_r);
    ys     = COORD_W'(ya_r);
    xbs    = COORD_W'(xb_r);
    ybs    = COORD_W'(yb_r);
    wc     = COORD_W'(w_r);
    hc     = COORD_W'(h_r);
    x_end  = xs + wc - COORD_W'(1);
    y_end  = ys + hc - COORD_W'(1);
    w_last = CNT_W'(w_r) - CNT_W'(1);
    h_last = CNT_W'(h_r) - CNT_W'(1);
    dx     = xbs - xs;
    dy     = ybs - ys;
    adx    = dx[COORD_W-1] ? -dx : dx;
    ady    = dy[COORD_W-1] ? -dy : dy;
    x_min  = dx[COORD_W-1] ? xbs : xs;
    y_min  = dy[COORD_W-1] ? ybs : ys;
  end

  assign is_vert = (xa_r == xb_r);
  assign is_horz = (ya_r == yb_r);

  logic signed [COORD_W-1:0] ox_ld, oy_ld;
  logic [CNT_W-1:0]          cl_ld, rl_ld;

  always_comb begin
    ox_ld = xs;
    oy_ld = ys;
    cl_ld = '0;
    rl_ld = '0;
    case (cmd.seg)
      SEG_LINE: begin
        if (is_vert) begin
          oy_ld = y_min;
          rl_ld = ady[CNT_W-1:0];
        end else begin
          ox_ld = x_min;
          cl_ld = adx[CNT_W-1:0];
        end
      end
      SEG_TOP: cl_ld = w_last;
      SEG_BOTTOM: begin
        oy_ld = y_end;
        cl_ld = w_last;
      end
      SEG_LEFT: rl_ld = h_last;
      SEG_RIGHT: begin
        ox_ld = x_end;
        rl_ld = h_last;
      end
      SEG_FILL: begin
        cl_ld = w_last;
        rl_ld = h_last;
      end
      default: ;
    endcase
  end

  // run walker
  logic signed [COORD_W-1:0] ox, cur_x, cur_y;
  logic [CNT_W-1:0]          col_cnt, row_cnt, cols_last, rows_last;
  logic                      col_end;

  assign col_end = (col_cnt == cols_last);

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      ox        <= ox_ld;
      cur_x     <= ox_ld;
      cur_y     <= oy_ld;
      col_cnt   <= '0;
      row_cnt   <= '0;
      cols_last <= cl_ld;
      rows_last <= rl_ld;
    end else if (cmd.advance) begin
      if (col_end) begin
        col_cnt <= '0;
        cur_x   <= ox;
        row_cnt <= row_cnt + CNT_W'(1);
        cur_y   <= cur_y + COORD_W'(1);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
        cur_x   <= cur_x + COORD_W'(1);
      end
    end
  end

  // pixel address, stage one: margin and clip
  logic signed [COORD_W-1:0] px, py, prow;
  logic                      pix_ok;

  always_comb begin
    px     = cur_x + COORD_W'(margin_left);
    py     = cur_y + COORD_W'(margin_top);
    prow   = COORD_W'(PANEL_SHORT - 1) - px;
    pix_ok = !px[COORD_W-1] && (px < COORD_W'(PANEL_SHORT)) &&
             !py[COORD_W-1] && (py < COORD_W'(PANEL_LONG));
  end

  logic [PX_W-1:0] pix_row;
  logic [PY_W-1:0] pix_py;
  logic [2:0]      pix_bit;

  always_ff @(posedge clk) begin
    if (cmd.addr_stage) begin
      pix_row <= PX_W'(prow);
      pix_py  <= PY_W'(py);
      pix_bit <= ~py[2:0];
    end
  end

  // stage two: rotated byte index
  logic [WIDE_W-1:0] idx;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;

  assign idx = WIDE_W'(pix_row) * WIDE_W'(ROW_BYTES) + WIDE_W'(pix_py >> 3);

  always_ff @(posedge clk) begin
    if (cmd.pix_read) begin
      wr_addr <= ADDR_W'(idx);
      wr_ok   <= (idx < WIDE_W'(STORE_BYTES));
    end
  end

  // frame store
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata, pix_byte;

  always_comb begin
    pix_byte          = ram_rdata;
    pix_byte[pix_bit] = ~ink_r ^ inv;
  end

  always_comb begin
    if (cmd.clear_write) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '1;
    end else begin
      ram_we    = cmd.pix_write && wr_ok;
      ram_waddr = wr_addr;
      ram_wdata = pix_byte;
    end
    ram_re    = cmd.pix_read || cmd.byte_read;
    ram_raddr = cmd.byte_read ? ADDR_W'(baddr_r) : ADDR_W'(idx);
  end

  rmrlp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read request result
  logic [BYTE_W-1:0] rd_hold;

  always_ff @(posedge clk) begin
    if (cmd.byte_capture) begin
      rd_hold <= (32'(baddr_r) < 32'(STORE_BYTES)) ? (ram_rdata ^ {BYTE_W{inv}}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status    <= cmd.res_status;
      read_data <= cmd.res_read ? rd_hold : '0;
    end
  end

  always_comb begin
    stat.clr_last   = (clr_cnt == ADDR_W'(STORE_BYTES - 1));
    stat.is_diag    = !is_vert && !is_horz;
    stat.rect_empty = (w_r == '0) || (h_r == '0);
    stat.pix_ok     = pix_ok;
    stat.pix_last   = col_end && (row_cnt == rows_last);
  end

endmodule

// File: design/rotated_mono_rect_line_plotter_top.sv
`timescale 1ns / 1ps

// Monochrome framebuffer plotter: one request draws a pixel, an axis-aligned
// line, a rectangle outline or fill, inverts the whole buffer, or reads one
// byte, and returns exactly one result. Coordinates get the margins added,
// are clipped to the 480x800 portrait area and land rotated in the landscape
// byte layout. After reset the block sweeps the 48000-byte store to white,
// one byte per cycle, before in_ready rises; margin writes are taken during
// that sweep. Each drawn pixel is a read-modify-write through the single
// store in an address, a read and a write step, while a clipped pixel stops
// after the address step; each line, outline side or fill adds a run setup
// step, and every request has an accept and a result step. Invert is a
// polarity flip. A finished result sits in the output register and the next
// request is taken while it waits.

module rotated_mono_rect_line_plotter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [rmrlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmrlp_pkg::MARGIN_W-1:0]       cfg_data,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rmrlp_pkg::REQ_W-1:0]          req_type,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    x_a,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    y_a,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    x_b,
  input  logic signed [rmrlp_pkg::XY_W-1:0]    y_b,
  input  logic [rmrlp_pkg::SIZE_W-1:0]         rect_width,
  input  logic [rmrlp_pkg::SIZE_W-1:0]         rect_height,
  input  logic                                 ink,
  input  logic [rmrlp_pkg::BADDR_W-1:0]        byte_addr,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 status,
  output logic [rmrlp_pkg::BYTE_W-1:0]         read_data
);

  import rmrlp_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: clearing sweep, request decode, run walking, result handoff
  rmrlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: margins, run counters, rotated addressing, store, result regs
  rmrlp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .x_a         (x_a),
    .y_a         (y_a),
    .x_b         (x_b),
    .y_b         (y_b),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .ink         (ink),
    .byte_addr   (byte_addr),
    .cmd         (cmd),
    .stat        (stat),
    .status      (status),
    .read_data   (read_data)
  );

endmodule

// File: dv/plotter_checker.sv
`timescale 1ns / 1ps

module plotter_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rmrlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmrlp_pkg::MARGIN_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [rmrlp_pkg::REQ_W-1:0]        req_type,
  input  logic signed [rmrlp_pkg::XY_W-1:0]  x_a,
  input  logic signed [rmrlp_pkg::XY_W-1:0]  y_a,
  input  logic signed [rmrlp_pkg::XY_W-1:0]  x_b,
  input  logic signed [rmrlp_pkg::XY_W-1:0]  y_b,
  input  logic [rmrlp_pkg::SIZE_W-1:0]       rect_width,
  input  logic [rmrlp_pkg::SIZE_W-1:0]       rect_height,
  input  logic                               ink,
  input  logic [rmrlp_pkg::BADDR_W-1:0]      byte_addr,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               status,
  input  logic [rmrlp_pkg::BYTE_W-1:0]       read_data,
  output int                                 mismatches,
  output int                                 pending
);
  import rmrlp_pkg::*;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] data;
  } plot_result_t;

  // shadow framebuffer, bits held in the polarity of the last invert
  logic [BYTE_W-1:0]   shadow_fb [STORE_BYTES];
  logic                fb_inverted;
  logic [MARGIN_W-1:0] left_margin;
  logic [MARGIN_W-1:0] top_margin;
  plot_result_t        owed_results [$];
  int                  err_count;
  int                  results_seen;

  task automatic draw_pixel(int x, int y, logic black);
    int px, py, idx;
    px = x + int'(left_margin);
    py = y + int'(top_margin);
    if (px < 0 || px >= PANEL_SHORT || py < 0 || py >= PANEL_LONG) return;
    idx = (PANEL_SHORT - 1 - px) * ROW_BYTES + py / 8;
    if (idx >= STORE_BYTES) return;
    shadow_fb[idx][7 - py % 8] = ~black ^ fb_inverted;
  endtask

  task automatic draw_hrun(int x0, int x1, int y, logic black);
    int lo, hi, x;
    lo = (x0 < x1) ? x0 : x1;
    hi = (x0 < x1) ? x1 : x0;
    for (x = lo; x <= hi; x++) draw_pixel(x, y, black);
  endtask

  task automatic draw_vrun(int x, int y0, int y1, logic black);
    int lo, hi, y;
    lo = (y0 < y1) ? y0 : y1;
    hi = (y0 < y1) ? y1 : y0;
    for (y = lo; y <= hi; y++) draw_pixel(x, y, black);
  endtask

  task automatic apply_request(output plot_result_t res);
    int xa, ya, xb, yb, w, h, r;
    logic black;
    xa = int'(x_a);
    ya = int'(y_a);
    xb = int'(x_b);
    yb = int'(y_b);
    w = int'(rect_width);
    h = int'(rect_height);
    black = ink;
    res = '0;
    case (req_type)
      REQ_PIXEL: draw_pixel(xa, ya, black);
      REQ_LINE: begin
        if (xa == xb) draw_vrun(xa, ya, yb, black);
        else if (ya == yb) draw_hrun(xa, xb, ya, black);
        else res.status = 1'b1;
      end
      REQ_OUTLINE: begin
        if (w > 0 && h > 0) begin
          draw_hrun(xa, xa + w - 1, ya, black);
          draw_hrun(xa, xa + w - 1, ya + h - 1, black);
          draw_vrun(xa, ya, ya + h - 1, black);
          draw_vrun(xa + w - 1, ya, ya + h - 1, black);
        end
      end
      REQ_FILL: begin
        if (w > 0 && h > 0)
          for (r = ya; r < ya + h; r++) draw_hrun(xa, xa + w - 1, r, black);
      end
      REQ_INVERT: fb_inverted = ~fb_inverted;
      REQ_READ: begin
        if (byte_addr < STORE_BYTES)
          res.data = shadow_fb[byte_addr] ^ {BYTE_W{fb_inverted}};
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    int i;
    plot_result_t want;
    if (rst) begin
      for (i = 0; i < STORE_BYTES; i++) shadow_fb[i] = '1;
      fb_inverted = 1'b0;
      left_margin = MARGIN_LEFT_RST;
      top_margin = MARGIN_TOP_RST;
      owed_results.delete();
      err_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MARGIN_LEFT) left_margin = cfg_data;
        else if (cfg_index == CFG_MARGIN_TOP) top_margin = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          if (err_count < 10)
            $display("result %0d arrived with no request outstanding", results_seen);
          err_count++;
        end else begin
          want = owed_results.pop_front();
          if (status !== want.status || read_data !== want.data) begin
            if (err_count < 10)
              $display("result %0d: status exp %0d got %0d, read_data exp %02h got %02h",
                       results_seen, want.status, status, want.data, read_data);
            err_count++;
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        apply_request(want);
        owed_results.push_back(want);
      end
    end
    mismatches <= err_count;
    pending <= owed_results.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rmrlp_pkg::*;

  localparam int HOLD_CYCLES  = 3000;  // long receiver hold-off
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 75;
  localparam int DRAIN_CYCLES = 50;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  // request codes that do nothing
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]       kind;
    logic signed [XY_W-1:0] xa;
    logic signed [XY_W-1:0] ya;
    logic signed [XY_W-1:0] xb;
    logic signed [XY_W-1:0] yb;
    logic [SIZE_W-1:0]      w;
    logic [SIZE_W-1:0]      h;
    logic                   ink;
    logic [BADDR_W-1:0]     addr;
  } plot_req_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [MARGIN_W-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [REQ_W-1:0]       req_type;
  logic signed [XY_W-1:0] x_a;
  logic signed [XY_W-1:0] y_a;
  logic signed [XY_W-1:0] x_b;
  logic signed [XY_W-1:0] y_b;
  logic [SIZE_W-1:0]      rect_width;
  logic [SIZE_W-1:0]      rect_height;
  logic                   ink;
  logic [BADDR_W-1:0]     byte_addr;
  logic                   out_valid;
  logic                   out_ready;
  logic                   status;
  logic [BYTE_W-1:0]      read_data;
  int                     mismatches;
  int                     pending;

  // idling modes per phase, and the one-shot long hold-off
  bit tx_idle;
  bit rx_idle;
  bit hold_off_req;

  // margins as last written, and the last corner drawn, for aimed reads
  logic [MARGIN_W-1:0] cur_left;
  logic [MARGIN_W-1:0] cur_top;
  int last_x;
  int last_y;

  rotated_mono_rect_line_plotter_top i_dut (.*);

  plotter_checker i_checker (.*);

  always #5 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic plot_req_t mk_req(logic [REQ_W-1:0] kind, int xa, int ya, int xb,
                                       int yb, int w, int h, int blk, int addr);
    plot_req_t r;
    r.kind = kind;
    r.xa = XY_W'(xa);
    r.ya = XY_W'(ya);
    r.xb = XY_W'(xb);
    r.yb = XY_W'(yb);
    r.w = SIZE_W'(w);
    r.h = SIZE_W'(h);
    r.ink = 1'(blk);
    r.addr = BADDR_W'(addr);
    return r;
  endfunction

  // mostly near the panel so the margins matter, now and then anywhere
  function automatic logic signed [XY_W-1:0] rand_coord(int lo, int hi);
    if ($urandom_range(0, 7) == 0) return XY_W'($urandom);
    return XY_W'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  function automatic plot_req_t random_request();
    plot_req_t r;
    int pick, sub, px, py;
    // every field starts as noise, the request type then overrides what it uses
    r.kind = REQ_PIXEL;
    r.xa = XY_W'($urandom);
    r.ya = XY_W'($urandom);
    r.xb = XY_W'($urandom);
    r.yb = XY_W'($urandom);
    r.w = SIZE_W'($urandom);
    r.h = SIZE_W'($urandom);
    r.ink = 1'($urandom);
    r.addr = BADDR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r.kind = REQ_PIXEL;
      r.xa = rand_coord(-300, 500);
      r.ya = rand_coord(-300, 820);
    end else if (pick < 38) begin
      r.kind = REQ_LINE;
      r.xa = rand_coord(-300, 500);
      r.ya = rand_coord(-300, 820);
      sub = $urandom_range(0, 19);
      if (sub < 8) begin
        r.xb = r.xa;
        r.yb = XY_W'(int'(r.ya) + int'($urandom_range(0, 80)) - 40);
      end else if (sub < 16) begin
        r.yb = r.ya;
        r.xb = XY_W'(int'(r.xa) + int'($urandom_range(0, 80)) - 40);
      end else if (sub < 18) begin
        // equal endpoints, one pixel
        r.xb = r.xa;
        r.yb = r.ya;
      end else if (sub == 19) begin
        // vertical across the whole coordinate range
        r.xb = r.xa;
        r.ya = XY_W'($urandom);
        r.yb = XY_W'($urandom);
      end
      // otherwise the noise endpoints give a diagonal line
    end else if (pick < 50) begin
      r.kind = REQ_OUTLINE;
      r.xa = rand_coord(-300, 500);
      r.ya = rand_coord(-300, 820);
      if ($urandom_range(0, 15) != 0) begin
        r.w = SIZE_W'($urandom_range(0, 20));
        r.h = SIZE_W'($urandom_range(0, 20));
      end
    end else if (pick < 62) begin
      r.kind = REQ_FILL;
      r.xa = rand_coord(-300, 500);
      r.ya = rand_coord(-300, 820);
      if ($urandom_range(0, 15) != 0) begin
        r.w = SIZE_W'($urandom_range(0, 16));
        r.h = SIZE_W'($urandom_range(0, 16));
      end else if ($urandom_range(0, 1) == 0) begin
        r.h = SIZE_W'($urandom_range(0, 3));
      end else begin
        r.w = SIZE_W'($urandom_range(0, 3));
      end
    end else if (pick < 65) begin
      r.kind = REQ_INVERT;
    end else if (pick < 94) begin
      r.kind = REQ_READ;
      sub = $urandom_range(0, 9);
      px = last_x + int'(cur_left);
      py = last_y + int'(cur_top);
      if (sub < 6 && px >= 0 && px < PANEL_SHORT && py >= 0 && py < PANEL_LONG)
        r.addr = BADDR_W'((PANEL_SHORT - 1 - px) * ROW_BYTES + py / 8);
      else if (sub < 8) r.addr = BADDR_W'($urandom_range(0, STORE_BYTES - 1));
      else if (sub == 9)
        r.addr = BADDR_W'($urandom_range(STORE_BYTES - 10, STORE_BYTES + 10));
    end else begin
      r.kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_A : REQ_SPARE_B;
    end
    // remember the corner so later reads land on drawn bytes
    if (r.kind == REQ_PIXEL || r.kind == REQ_LINE || r.kind == REQ_OUTLINE ||
        r.kind == REQ_FILL) begin
      last_x = int'(r.xa);
      last_y = int'(r.ya);
    end
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MARGIN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_margins(logic [MARGIN_W-1:0] left, logic [MARGIN_W-1:0] top);
    write_reg(CFG_MARGIN_LEFT, left);
    write_reg(CFG_MARGIN_TOP, top);
    cur_left = left;
    cur_top = top;
  endtask

  // offer one request, holding it until the block takes it
  task automatic drive_request(plot_req_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    x_a <= r.xa;
    y_a <= r.ya;
    x_b <= r.xb;
    y_b <= r.yb;
    rect_width <= r.w;
    rect_height <= r.h;
    ink <= r.ink;
    byte_addr <= r.addr;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // stop offering and wait until every request has its result back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random stalls per result, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int p, n;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = '0;
    x_a = '0;
    y_a = '0;
    x_b = '0;
    y_b = '0;
    rect_width = '0;
    rect_height = '0;
    ink = 1'b0;
    byte_addr = '0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_off_req = 1'b0;
    cur_left = MARGIN_LEFT_RST;
    cur_top = MARGIN_TOP_RST;
    last_x = 0;
    last_y = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part with zero margins so portrait corners map to known bytes;
    // the writes land during the clearing sweep
    write_reg(CFG_SPARE_A, 8'hA5);
    set_margins(8'd0, 8'd0);
    drive_request(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 47900));
    drive_request(mk_req(REQ_PIXEL, 479, 799, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 99));
    // clipped just outside the left and right edges and at the coordinate extremes
    drive_request(mk_req(REQ_PIXEL, -1, 0, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_PIXEL, 480, 799, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_PIXEL, -2048, -2048, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_PIXEL, 2047, 2047, 0, 0, 0, 0, 1, 0));
    // lines with swapped endpoints, a single point, a diagonal, full width
    drive_request(mk_req(REQ_LINE, 5, 20, 5, 10, 0, 0, 1, 0));
    drive_request(mk_req(REQ_LINE, 30, 3, 0, 3, 0, 0, 1, 0));
    drive_request(mk_req(REQ_LINE, 7, 7, 7, 7, 0, 0, 1, 0));
    drive_request(mk_req(REQ_LINE, 0, 0, 5, 6, 0, 0, 1, 0));
    drive_request(mk_req(REQ_LINE, -2048, 100, 2047, 100, 0, 0, 1, 0));
    // empty rectangles draw nothing
    drive_request(mk_req(REQ_OUTLINE, 2, 2, 0, 0, 0, 5, 1, 0));
    drive_request(mk_req(REQ_FILL, 2, 2, 0, 0, 5, 0, 1, 0));
    // largest sizes
    drive_request(mk_req(REQ_OUTLINE, -600, 50, 0, 0, 1023, 1023, 1, 0));
    drive_request(mk_req(REQ_FILL, -300, 200, 0, 0, 1023, 2, 1, 0));
    drive_request(mk_req(REQ_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
    drive_request(mk_req(REQ_FILL, 300, -100, 0, 0, 2, 1023, 0, 0));
    // last byte, first byte past the store, top of the address range
    drive_request(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES - 1));
    drive_request(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, STORE_BYTES));
    drive_request(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    drive_request(mk_req(REQ_SPARE_A, 0, 0, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_SPARE_B, 0, 0, 0, 0, 0, 0, 1, 0));
    drive_request(mk_req(REQ_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // random phases, each under its own margins and idling mix
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_margins(8'd255, 8'd255);
        1: set_margins(MARGIN_LEFT_RST, MARGIN_TOP_RST);
        2: set_margins(8'd0, 8'd255);
        default: set_margins(MARGIN_W'($urandom), MARGIN_W'($urandom));
      endcase
      if (p % 3 == 0) write_reg(CFG_SPARE_B, MARGIN_W'($urandom));
      tx_idle = (p % 4 != 1);
      rx_idle = (p % 3 != 2);
      if (p == 4) begin
        // receiver stops for a long while, sender keeps pushing back to back
        hold_off_req = 1'b1;
        tx_idle = 1'b0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) drive_request(random_request());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
